@@ hw/rtl/ctfl_pkg.sv @@
// ----------------------------------------------------------------------------
// ctfl_pkg: shared types and constants of the clamped table function lookup
// Item layouts, configuration fields, register indexes and command codes.
// ----------------------------------------------------------------------------
package ctfl_pkg;

  // Q16.16 fixed point: number of fraction bits.
  localparam int FRAC_BITS = 16;

  // Configuration port: five registers at byte addresses 4*i.
  localparam int PADDR_W   = 5;
  localparam int REG_LSB   = 2;
  localparam int PDATA_W   = 32;

  // Reset values of the configuration registers.
  localparam logic signed [31:0] LOW_BOUND_RST      = 32'sd0;
  localparam logic signed [31:0] HIGH_BOUND_RST     = 32'sd65536;
  localparam logic        [30:0] SCALE_SLOPE_RST    = 31'd67043328;
  localparam logic signed [31:0] SCALE_OFFSET_RST   = 32'sd32768;
  localparam logic        [10:0] ENTRIES_IN_USE_RST = 11'd1024;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_LOW_BOUND      = 3'd0,
    REG_HIGH_BOUND     = 3'd1,
    REG_SCALE_SLOPE    = 3'd2,
    REG_SCALE_OFFSET   = 3'd3,
    REG_ENTRIES_IN_USE = 3'd4
  } reg_idx_e;

  // Function codes carried by an input item.
  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_NEAREST = 2'd1,
    FUNC_INTERP  = 2'd2
  } func_e;

  // What the back end does with a classified item.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_BLEND = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [10:0]        entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mapped_value;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic        [30:0] scale_slope;
    logic signed [31:0] scale_offset;
    logic        [10:0] entries_in_use;
  } cfg_t;

  // Control part of a command passed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [15:0] weight;
    logic        last;
  } ctl_t;

endpackage

@@ hw/rtl/ctfl_ram.sv @@
// ----------------------------------------------------------------------------
// ctfl_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module ctfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [WIDTH-1:0]         ra_data_o,
  output logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule

@@ hw/rtl/ctfl_fifo.sv @@
// ----------------------------------------------------------------------------
// ctfl_fifo: small synchronous queue
// Register-based queue with a power-of-two depth and a fill count.
// ----------------------------------------------------------------------------
module ctfl_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/ctfl_front.sv @@
// ----------------------------------------------------------------------------
// ctfl_front: item intake and classification
// Registers each item with its scaled product, then works out the table
// address, weight and command kind for the back end.
// ----------------------------------------------------------------------------
module ctfl_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 11
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctfl_pkg::cfg_t          cfg_i,
  input  logic                    item_valid_i,
  input  ctfl_pkg::in_item_t      item_i,
  output logic                    full_o,
  output logic                    cmd_valid_o,
  input  logic                    cmd_ready_i,
  output ctfl_pkg::ctl_t          cmd_ctl_o,
  output logic [AW-1:0]           cmd_addr_o,
  output logic [VALUE_WIDTH-1:0]  cmd_wdata_o
);

  localparam int                PW      = 63;
  localparam int                XW      = 48;
  localparam logic [31:0]       DEPTH32 = 32'(TABLE_DEPTH);

  logic                     accept;
  logic signed [PW-1:0]     prod_d, f1_prod_q;
  logic                     below_d, above_d;
  logic                     f1_below_q, f1_above_q;
  logic                     f1_valid_q, f1_valid_d;
  ctfl_pkg::in_item_t       f1_item_q;
  logic signed [XW-1:0]     x_scaled;
  logic [31:0]              idx_u;
  logic [15:0]              weight;
  logic [31:0]              cnt;
  logic [31:0]              last_idx;
  logic [31:0]              slot32;

  assign full_o      = f1_valid_q && !cmd_ready_i;
  assign accept      = item_valid_i && !full_o;
  assign cmd_valid_o = f1_valid_q;

  // Sample times slope is exact; the bound checks run alongside it.
  assign prod_d  = PW'($signed(item_i.sample)) * PW'($signed({1'b0, cfg_i.scale_slope}));
  assign below_d = $signed(item_i.sample) < $signed(cfg_i.low_bound);
  assign above_d = $signed(cfg_i.high_bound) < $signed(item_i.sample);

  // The stage empties when its command moves into the queue.
  always_comb begin
    f1_valid_d = f1_valid_q;
    if (accept) begin
      f1_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      f1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_item_q  <= item_i;
      f1_prod_q  <= prod_d;
      f1_below_q <= below_d;
      f1_above_q <= above_d;
    end
  end

  // Scaled index: floor of the product in Q16.16 plus the offset.
  assign x_scaled = XW'(f1_prod_q >>> ctfl_pkg::FRAC_BITS) + XW'(cfg_i.scale_offset);
  assign idx_u    = x_scaled[XW-1:ctfl_pkg::FRAC_BITS];
  assign weight   = x_scaled[ctfl_pkg::FRAC_BITS-1:0];
  assign slot32   = 32'(f1_item_q.entry_index);

  // Entries in use, kept between one and the table depth.
  always_comb begin
    if (cfg_i.entries_in_use == '0) begin
      cnt = 32'd1;
    end else if (32'(cfg_i.entries_in_use) > DEPTH32) begin
      cnt = DEPTH32;
    end else begin
      cnt = 32'(cfg_i.entries_in_use);
    end
    last_idx = cnt - 32'd1;
  end

  // Classify the item into a command for the back end.
  always_comb begin
    cmd_ctl_o.kind   = ctfl_pkg::CMD_NOP;
    cmd_ctl_o.weight = '0;
    cmd_ctl_o.last   = f1_item_q.last_sample;
    cmd_addr_o       = '0;
    cmd_wdata_o      = VALUE_WIDTH'($signed(f1_item_q.entry_value));
    case (f1_item_q.func)
      ctfl_pkg::FUNC_WRITE: begin
        if (slot32 <= DEPTH32) begin
          cmd_ctl_o.kind = ctfl_pkg::CMD_WRITE;
          cmd_addr_o     = slot32[AW-1:0];
        end
      end
      ctfl_pkg::FUNC_NEAREST, ctfl_pkg::FUNC_INTERP: begin
        cmd_ctl_o.kind = ctfl_pkg::CMD_READ;
        if (f1_below_q) begin
          cmd_addr_o = '0;
        end else if (f1_above_q) begin
          cmd_addr_o = last_idx[AW-1:0];
        end else if (x_scaled[XW-1]) begin
          // A negative index saturates to the first entry.
          cmd_addr_o = '0;
        end else if (idx_u > last_idx) begin
          // An index past the end saturates to the last entry in use.
          cmd_addr_o = last_idx[AW-1:0];
        end else begin
          cmd_addr_o = idx_u[AW-1:0];
          // A blend with zero weight is the entry itself.
          if (f1_item_q.func == ctfl_pkg::FUNC_INTERP && weight != '0) begin
            cmd_ctl_o.kind   = ctfl_pkg::CMD_BLEND;
            cmd_ctl_o.weight = weight;
          end
        end
      end
      default: begin
        cmd_ctl_o.kind = ctfl_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

@@ hw/rtl/ctfl_back.sv @@
// ----------------------------------------------------------------------------
// ctfl_back: table access and result formation
// Issues one command a cycle to the table RAM while the result queue has room,
// blends the entries read back and queues the results.
// ----------------------------------------------------------------------------
module ctfl_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32,
  parameter int AW          = 11,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_pop_o,
  input  ctfl_pkg::ctl_t         cmd_ctl_i,
  input  logic [AW-1:0]          cmd_addr_i,
  input  logic [VALUE_WIDTH-1:0] cmd_wdata_i,
  input  logic                   pop_i,
  output logic                   empty_o,
  output ctfl_pkg::out_item_t    out_item_o
);

  localparam int CW = $clog2(OUT_DEPTH + 1);
  localparam int DW = VALUE_WIDTH + 1;
  localparam int MW = VALUE_WIDTH + 18;
  localparam int RW = VALUE_WIDTH + 2;
  localparam int EW = (RW > 32) ? RW : 32;
  localparam int OW = $bits(ctfl_pkg::out_item_t);

  logic                        issue;
  logic [CW-1:0]               out_cnt;
  logic                        b2_valid_q;
  ctfl_pkg::ctl_t              b2_ctl_q;
  logic [VALUE_WIDTH-1:0]      ra_data, rb_data;
  logic signed [DW-1:0]        diff;
  logic signed [MW-1:0]        blend_prod;
  logic signed [RW-1:0]        blend_sum;
  logic signed [EW-1:0]        a_ext, sum_ext;
  ctfl_pkg::out_item_t         res_item;
  logic [OW-1:0]               out_data;

  // Issue only while the result queue has room for everything in flight.
  assign issue = cmd_valid_i &&
                 ((CW + 1)'(out_cnt) + (CW + 1)'(b2_valid_q) < (CW + 1)'(OUT_DEPTH));
  assign cmd_pop_o = issue;

  ctfl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH + 1)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (issue && cmd_ctl_i.kind == ctfl_pkg::CMD_WRITE),
    .waddr_i   (cmd_addr_i),
    .wdata_i   (cmd_wdata_i),
    .ra_addr_i (cmd_addr_i),
    .rb_addr_i (cmd_addr_i + AW'(1)),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  // Command control travels alongside the RAM read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else begin
      b2_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b2_ctl_q <= cmd_ctl_i;
    end
  end

  // Blend: a plus the floor of (b - a) times the weight over 65536.
  assign diff       = DW'($signed(rb_data)) - DW'($signed(ra_data));
  assign blend_prod = MW'(diff) * MW'($signed({1'b0, b2_ctl_q.weight}));
  assign blend_sum  = RW'($signed(ra_data)) + RW'(blend_prod >>> ctfl_pkg::FRAC_BITS);
  assign a_ext      = EW'($signed(ra_data));
  assign sum_ext    = EW'(blend_sum);

  // Select the result; writes and unused codes give zero.
  always_comb begin
    res_item.last_result = b2_ctl_q.last;
    case (b2_ctl_q.kind)
      ctfl_pkg::CMD_READ:  res_item.mapped_value = a_ext[31:0];
      ctfl_pkg::CMD_BLEND: res_item.mapped_value = sum_ext[31:0];
      default:             res_item.mapped_value = '0;
    endcase
  end

  ctfl_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b2_valid_q),
    .data_i  (res_item),
    .full_o  (),
    .pop_i   (pop_i),
    .data_o  (out_data),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign out_item_o = out_data;

endmodule

@@ hw/rtl/clamped_table_function_lookup_core.sv @@
// ----------------------------------------------------------------------------
// clamped_table_function_lookup_core: Q16.16 function table lookup
// Path: front stage, command queue, RAM stage and result queue, in order.
// Throughput: one item per cycle unless a queue backs up; two RAM read ports
// serve a blend in one pass. Reset clears control state, sets configuration
// to reset values; the table is undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module clamped_table_function_lookup_core #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  ctfl_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output ctfl_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctfl_pkg::PADDR_W-1:0]  paddr,
  input  logic [ctfl_pkg::PDATA_W-1:0]  pwdata,
  output logic [ctfl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int AW        = $clog2(TABLE_DEPTH + 1);
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int CMD_W     = $bits(ctfl_pkg::ctl_t) + AW + VALUE_WIDTH;

  ctfl_pkg::cfg_t          cfg_q, cfg_d;
  logic [2:0]              reg_sel;
  logic                    cfg_we;
  logic                    f_cmd_valid, q_full;
  ctfl_pkg::ctl_t          f_ctl, q_ctl;
  logic [AW-1:0]           f_addr, q_addr;
  logic [VALUE_WIDTH-1:0]  f_wdata, q_wdata;
  logic [CMD_W-1:0]        q_data;
  logic                    q_empty, q_pop;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_sel = paddr[ctfl_pkg::PADDR_W-1:ctfl_pkg::REG_LSB];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (reg_sel)
        ctfl_pkg::REG_LOW_BOUND:      cfg_d.low_bound      = pwdata;
        ctfl_pkg::REG_HIGH_BOUND:     cfg_d.high_bound     = pwdata;
        ctfl_pkg::REG_SCALE_SLOPE:    cfg_d.scale_slope    = pwdata[30:0];
        ctfl_pkg::REG_SCALE_OFFSET:   cfg_d.scale_offset   = pwdata;
        ctfl_pkg::REG_ENTRIES_IN_USE: cfg_d.entries_in_use = pwdata[10:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_bound      <= ctfl_pkg::LOW_BOUND_RST;
      cfg_q.high_bound     <= ctfl_pkg::HIGH_BOUND_RST;
      cfg_q.scale_slope    <= ctfl_pkg::SCALE_SLOPE_RST;
      cfg_q.scale_offset   <= ctfl_pkg::SCALE_OFFSET_RST;
      cfg_q.entries_in_use <= ctfl_pkg::ENTRIES_IN_USE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      ctfl_pkg::REG_LOW_BOUND:      prdata = cfg_q.low_bound;
      ctfl_pkg::REG_HIGH_BOUND:     prdata = cfg_q.high_bound;
      ctfl_pkg::REG_SCALE_SLOPE:    prdata = {1'b0, cfg_q.scale_slope};
      ctfl_pkg::REG_SCALE_OFFSET:   prdata = cfg_q.scale_offset;
      ctfl_pkg::REG_ENTRIES_IN_USE: prdata = 32'(cfg_q.entries_in_use);
      default:                      prdata = '0;
    endcase
  end

  ctfl_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (push),
    .item_i       (in_item_i),
    .full_o       (full),
    .cmd_valid_o  (f_cmd_valid),
    .cmd_ready_i  (!q_full),
    .cmd_ctl_o    (f_ctl),
    .cmd_addr_o   (f_addr),
    .cmd_wdata_o  (f_wdata)
  );

  // Command queue between the front and back ends.
  ctfl_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_cmd_valid),
    .data_i  ({f_ctl, f_addr, f_wdata}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty),
    .count_o ()
  );

  assign {q_ctl, q_addr, q_wdata} = q_data;

  ctfl_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .cmd_ctl_i   (q_ctl),
    .cmd_addr_i  (q_addr),
    .cmd_wdata_i (q_wdata),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule

@@ hw/rtl/ctfl_checker.sv @@
// ----------------------------------------------------------------------------
// ctfl_checker: port-level checks of the lookup core
// Tracks items in flight and checks results against reset, count and latency.
// ----------------------------------------------------------------------------
module ctfl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ctfl_pkg::out_item_t out_item_o
);

  // Front stage, command queue, RAM stage and result queue.
  localparam logic [4:0] MAX_IN_FLIGHT = 5'd10;

  logic [4:0] pending_q, pending_d;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + 5'd1;
    end else if (out_acc && !in_acc) begin
      pending_d = pending_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // No result is offered while reset is held.
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result offered during reset");

  // A result is offered only for an item that was taken in.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> pending_q != 5'd0)
    else $error("result offered with no item outstanding");

  // Items in flight never exceed the storage of the pipeline.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= MAX_IN_FLIGHT)
    else $error("more items in flight than the pipeline holds");

  // An item into an idle block is offered after the front, queue and RAM stages.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pending_q == 5'd0 |-> ##4 !empty)
    else $error("result of an item into an idle block is late");

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed or vanished");

endmodule

bind clamped_table_function_lookup_core ctfl_checker u_ctfl_checker (.*);
